>>> hw/rtl/vvps_pkg.sv
// Shared types, constants and helpers for the velocity-Verlet particle step core.
// Holds the request/response beat structs, CSR indexes, fault codes and saturation helper.
// No dependencies.
package vvps_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int CFG_W     = 31;
   // kick quotient is clamped to +-2^40; magnitude needs 41 bits, signed 42
   localparam int KICK_QW   = 41;
   localparam int KICK_W    = KICK_QW + 1;
   localparam int DIV_STEPS = 2;

   localparam logic [KICK_QW-1:0] KICK_CLAMP = {1'b1, {(KICK_QW-1){1'b0}}};

   localparam logic CMD_INITIAL = 1'b0;
   localparam logic CMD_FINAL   = 1'b1;

   localparam logic [1:0] FAULT_OK        = 2'd0;
   localparam logic [1:0] FAULT_SAT       = 2'd1;
   localparam logic [1:0] FAULT_ZERO_MASS = 2'd2;

   typedef enum logic [1:0] {
      CSR_TIME_STEP  = 2'd0,
      CSR_HALF_STEP  = 2'd1,
      CSR_VEL_LIMIT  = 2'd2,
      CSR_XSPH       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                     cmd;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic signed [DATA_W-1:0] vel_z;
      logic signed [DATA_W-1:0] force_x;
      logic signed [DATA_W-1:0] force_y;
      logic signed [DATA_W-1:0] force_z;
      logic [CFG_W-1:0]         mass;
      logic signed [DATA_W-1:0] smooth_x;
      logic signed [DATA_W-1:0] smooth_y;
      logic signed [DATA_W-1:0] smooth_z;
      logic signed [DATA_W-1:0] energy_rate;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] new_vel_x;
      logic signed [DATA_W-1:0] new_vel_y;
      logic signed [DATA_W-1:0] new_vel_z;
      logic signed [DATA_W-1:0] est_vel_x;
      logic signed [DATA_W-1:0] est_vel_y;
      logic signed [DATA_W-1:0] est_vel_z;
      logic signed [DATA_W-1:0] move_x;
      logic signed [DATA_W-1:0] move_y;
      logic signed [DATA_W-1:0] move_z;
      logic signed [DATA_W-1:0] energy_step;
      logic                     was_capped;
      logic [1:0]               fault;
   } rsp_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] val;
   } sat_type;

   // clamp a wide signed value to the DATA_W range
   function automatic sat_type sat_data(input logic signed [63:0] x);
      sat_type          r;
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      r.hit = 1'b0;
      r.val = x[DATA_W-1:0];
      if (x > hi) begin
         r.hit = 1'b1;
         r.val = hi[DATA_W-1:0];
      end else if (x < lo) begin
         r.hit = 1'b1;
         r.val = lo[DATA_W-1:0];
      end
      return r;
   endfunction

   // divide by 2^FRAC_BITS, truncating toward zero
   function automatic logic signed [63:0] frac_trunc(input logic signed [63:0] x);
      logic signed [63:0] bias;
      bias = (64'sd1 <<< FRAC_BITS) - 64'sd1;
      if (x < 0) begin
         return (x + bias) >>> FRAC_BITS;
      end
      return x >>> FRAC_BITS;
   endfunction

endpackage

>>> hw/rtl/vvps_div.sv
// Pipelined restoring divider, unsigned, STEPS quotient bits per stage.
// Requires num < den * 2^Q_W. No package dependencies.
module vvps_div #(
   parameter int NUM_W = 62,
   parameter int DEN_W = 31,
   parameter int Q_W   = 41,
   parameter int STEPS = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quot
);
   localparam int LAT = (Q_W + STEPS - 1) / STEPS;
   localparam int W   = DEN_W + Q_W;

   // work word: partial remainder on top, numerator bits shifting out, quotient shifting in
   logic [W-1:0]     src      [LAT];
   logic [DEN_W-1:0] dsrc     [LAT];
   logic [W-1:0]     work_in  [LAT];
   logic [W-1:0]     work_ff  [LAT];
   logic [DEN_W-1:0] den_ff   [LAT];

   assign src[0]  = {DEN_W'(num[NUM_W-1:Q_W]), num[Q_W-1:0]};
   assign dsrc[0] = den;

   for (genvar s = 1; s < LAT; s++) begin : g_link
      assign src[s]  = work_ff[s-1];
      assign dsrc[s] = den_ff[s-1];
   end

   for (genvar s = 0; s < LAT; s++) begin : g_stage
      // compare-subtract steps for this stage
      always_comb begin
         logic [W-1:0]   w;
         logic [DEN_W:0] t;
         logic [DEN_W:0] d;
         logic           qb;
         w = src[s];
         d = {1'b0, dsrc[s]};
         for (int i = 0; i < STEPS; i++) begin
            if (s * STEPS + i < Q_W) begin
               t  = {w[W-1:Q_W], w[Q_W-1]};
               qb = (t >= d);
               if (qb) begin
                  t = t - d;
               end
               w = {t[DEN_W-1:0], w[Q_W-2:0], qb};
            end
         end
         work_in[s] = w;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            work_ff[s] <= work_in[s];
            den_ff[s]  <= dsrc[s];
         end
      end
   end

   assign quot = work_ff[LAT-1][Q_W-1:0];

endmodule

>>> hw/rtl/vvps_sqrt.sv
// Pipelined digit-by-digit integer square root, STEPS root bits per stage.
// Gives the floor root and whether a remainder is left. No package dependencies.
module vvps_sqrt #(
   parameter int IN_W  = 64,
   parameter int STEPS = 2
) (
   input  logic              clock,
   input  logic              en,
   input  logic [IN_W-1:0]   radicand,
   output logic [IN_W/2-1:0] root,
   output logic              rem_nz
);
   localparam int ROOT_W = IN_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int LAT    = (ROOT_W + STEPS - 1) / STEPS;
   localparam int W      = REM_W + ROOT_W + IN_W;

   // state word: {remainder, root, radicand bits not yet consumed}
   logic [W-1:0] src     [LAT];
   logic [W-1:0] work_in [LAT];
   logic [W-1:0] work_ff [LAT];

   assign src[0] = {{REM_W{1'b0}}, {ROOT_W{1'b0}}, radicand};

   for (genvar s = 1; s < LAT; s++) begin : g_link
      assign src[s] = work_ff[s-1];
   end

   for (genvar s = 0; s < LAT; s++) begin : g_stage
      always_comb begin
         logic [REM_W-1:0]  rem;
         logic [ROOT_W-1:0] rt;
         logic [IN_W-1:0]   rest;
         logic [REM_W+1:0]  t;
         logic [REM_W+1:0]  trial;
         {rem, rt, rest} = src[s];
         for (int i = 0; i < STEPS; i++) begin
            if (s * STEPS + i < ROOT_W) begin
               t     = {rem, rest[IN_W-1:IN_W-2]};
               trial = (REM_W + 2)'({rt, 2'b01});
               rest  = {rest[IN_W-3:0], 2'b00};
               if (t >= trial) begin
                  t  = t - trial;
                  rt = {rt[ROOT_W-2:0], 1'b1};
               end else begin
                  rt = {rt[ROOT_W-2:0], 1'b0};
               end
               rem = t[REM_W-1:0];
            end
         end
         work_in[s] = {rem, rt, rest};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            work_ff[s] <= work_in[s];
         end
      end
   end

   assign root   = work_ff[LAT-1][ROOT_W+IN_W-1:IN_W];
   assign rem_nz = |work_ff[LAT-1][W-1:ROOT_W+IN_W];

endmodule

>>> hw/rtl/vvps_dly.sv
// Enabled delay line that carries valid bits and side data next to an arithmetic unit.
// No package dependencies.
module vvps_dly #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);
   logic [W-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            stage_ff[i] <= '0;
         end
      end else if (en) begin
         stage_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign q = stage_ff[DEPTH-1];

endmodule

>>> hw/rtl/velocity_verlet_particle_step_core.sv
// Velocity-Verlet half step with speed cap, Q16.16, one particle per beat.
// Uses vvps_pkg, vvps_div, vvps_sqrt and vvps_dly.
//
// Usage:
//   req_* carries one particle beat (valid/ready); rsp_* returns one result beat
//   per request, in order. csr_* writes time_step, half_step_factor,
//   velocity_limit and xsph_enable (index 0..3); write only while idle.
//   On its way from the request to rsp_valid a beat passes the kick multiply,
//   a 21-stage kick divider, speed-squared sum, a 16-stage square root,
//   a 16-stage cap divider, then the position/energy multiply and rounding.
//   Throughput is one beat per cycle unless stalled: every stage holds one particle.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken, so req_ready = !rsp_valid || rsp_ready. When the
//   receiver stalls, all stages freeze and nothing is dropped or repeated.
//   Synchronous reset clears the CSRs to zero and all stage valid bits.
module velocity_verlet_particle_step_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vvps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vvps_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [30:0]       csr_wdata
);
   import vvps_pkg::*;

   localparam int KDIV_NUM_W = 62;
   localparam int CDIV_NUM_W = 62;
   localparam int CDIV_QW    = CFG_W;
   localparam int ROOT_W     = 32;
   localparam int KDIV_LAT   = (KICK_QW + DIV_STEPS - 1) / DIV_STEPS;
   localparam int SQRT_LAT   = (ROOT_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int CDIV_LAT   = (CDIV_QW + DIV_STEPS - 1) / DIV_STEPS;

   typedef struct packed {
      logic                      valid;
      req_type                   req;
      logic [2:0][2*DATA_W-1:0]  prod;
   } s1_type;

   typedef struct packed {
      logic       valid;
      req_type    req;
      logic [2:0] psign;
      logic [2:0] kovf;
   } kside_type;

   typedef struct packed {
      logic                     valid;
      req_type                  req;
      logic [2:0][DATA_W-1:0]   v;
      logic [2:0][KICK_W-1:0]   kick;
      logic                     sat;
   } s3_type;

   typedef struct packed {
      s3_type                      base;
      logic [2:0][2*DATA_W-1:0]    sq;
      logic [2:0][CDIV_NUM_W-1:0]  cnum;
   } s4_type;

   typedef struct packed {
      s3_type                      base;
      logic                        cap;
      logic [2:0][CDIV_NUM_W-1:0]  cnum;
   } qside_type;

   typedef struct packed {
      s3_type base;
      logic   cap;
   } cside_type;

   typedef struct packed {
      logic                   valid;
      logic                   cmd;
      logic [DATA_W-1:0]      er;
      logic [2:0][DATA_W-1:0] v;
      logic [2:0][DATA_W-1:0] est;
      logic [2:0][DATA_W:0]   d;
      logic                   sat;
      logic                   esat;
      logic                   cap;
      logic                   zm;
   } s7_type;

   typedef struct packed {
      logic                     valid;
      logic                     cmd;
      logic [2:0][DATA_W-1:0]   v;
      logic [2:0][DATA_W-1:0]   est;
      logic [2:0][2*DATA_W-1:0] mprod;
      logic [2*DATA_W-1:0]      eprod;
      logic                     sat;
      logic                     esat;
      logic                     cap;
      logic                     zm;
   } s8_type;

   function automatic logic [DATA_W-1:0] lane_vel(input req_type r, input int k);
      case (k)
         0:       return r.vel_x;
         1:       return r.vel_y;
         default: return r.vel_z;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] lane_force(input req_type r, input int k);
      case (k)
         0:       return r.force_x;
         1:       return r.force_y;
         default: return r.force_z;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] lane_smooth(input req_type r, input int k);
      case (k)
         0:       return r.smooth_x;
         1:       return r.smooth_y;
         default: return r.smooth_z;
      endcase
   endfunction

   // ---------------------------------------------------------------- CSRs
   logic [CFG_W-1:0]   time_step_ff;
   logic [CFG_W-1:0]   half_step_ff;
   logic [CFG_W-1:0]   vel_limit_ff;
   logic               xsph_ff;
   logic [2*CFG_W-1:0] lim_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= '0;
         half_step_ff <= '0;
         vel_limit_ff <= '0;
         xsph_ff      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TIME_STEP: time_step_ff <= csr_wdata;
            CSR_HALF_STEP: half_step_ff <= csr_wdata;
            CSR_VEL_LIMIT: vel_limit_ff <= csr_wdata;
            CSR_XSPH:      xsph_ff      <= csr_wdata[0];
         endcase
      end
   end

   // squared limit follows the limit register
   always_ff @(posedge clock) begin
      lim_sq_ff <= vel_limit_ff * vel_limit_ff;
   end

   // ---------------------------------------------------------------- flow control
   logic    adv;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------------------------------------------------------- S0: input beat
   logic    s0_valid_ff;
   req_type s0_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_req_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------- S1: factor * force
   s1_type s1_in, s1_ff;

   always_comb begin
      s1_in.valid = s0_valid_ff;
      s1_in.req   = s0_req_ff;
      for (int k = 0; k < 3; k++) begin
         s1_in.prod[k] = $signed({1'b0, half_step_ff}) * $signed(lane_force(s0_req_ff, k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else if (adv) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------- S2: magnitude, clamp check
   kside_type                  s2_side_in, s2_side_ff;
   logic [2:0][KDIV_NUM_W-1:0] s2_pmag_in, s2_pmag_ff;

   always_comb begin
      logic [2*DATA_W-1:0] pm;
      s2_side_in.valid = s1_ff.valid;
      s2_side_in.req   = s1_ff.req;
      for (int k = 0; k < 3; k++) begin
         pm = s1_ff.prod[k][2*DATA_W-1] ? (2*DATA_W)'(0) - s1_ff.prod[k] : s1_ff.prod[k];
         s2_pmag_in[k]       = pm[KDIV_NUM_W-1:0];
         s2_side_in.psign[k] = s1_ff.prod[k][2*DATA_W-1];
         // quotient would reach 2^41: clamp regardless of the low bits
         s2_side_in.kovf[k]  = CFG_W'(pm[KDIV_NUM_W-1:KICK_QW]) >= s1_ff.req.mass;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff <= '0;
      end else if (adv) begin
         s2_side_ff <= s2_side_in;
      end
      if (adv) begin
         s2_pmag_ff <= s2_pmag_in;
      end
   end

   // ---------------------------------------------------------------- kick dividers
   logic [KICK_QW-1:0] kq [3];
   kside_type          kd_side;

   for (genvar k = 0; k < 3; k++) begin : g_kdiv
      vvps_div #(
         .NUM_W (KDIV_NUM_W),
         .DEN_W (CFG_W),
         .Q_W   (KICK_QW),
         .STEPS (DIV_STEPS)
      ) u_kdiv (
         .clock (clock),
         .en    (adv),
         .num   (s2_pmag_ff[k]),
         .den   (s2_side_ff.req.mass),
         .quot  (kq[k])
      );
   end

   vvps_dly #(
      .W     ($bits(kside_type)),
      .DEPTH (KDIV_LAT)
   ) u_kdly (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .d     (s2_side_ff),
      .q     (kd_side)
   );

   // ---------------------------------------------------------------- S3: clamp kick, add
   s3_type s3_in, s3_ff;

   always_comb begin
      logic [KICK_QW-1:0]  qm;
      logic [KICK_W-1:0]   kk;
      sat_type             sv;
      s3_in.valid = kd_side.valid;
      s3_in.req   = kd_side.req;
      s3_in.sat   = 1'b0;
      for (int k = 0; k < 3; k++) begin
         qm = (kd_side.kovf[k] || kq[k] > KICK_CLAMP) ? KICK_CLAMP : kq[k];
         if (kd_side.req.mass == '0) begin
            qm = '0;
         end
         kk = kd_side.psign[k] ? KICK_W'(0) - {1'b0, qm} : {1'b0, qm};
         sv = sat_data(64'($signed(lane_vel(kd_side.req, k))) + 64'($signed(kk)));
         s3_in.kick[k] = kk;
         s3_in.v[k]    = sv.val;
         s3_in.sat     = s3_in.sat | sv.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff <= '0;
      end else if (adv) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------------------------------------------------------- S4: squares, cap numerators
   s4_type s4_in, s4_ff;

   always_comb begin
      logic [DATA_W-1:0] va;
      s4_in.base = s3_ff;
      for (int k = 0; k < 3; k++) begin
         va = s3_ff.v[k][DATA_W-1] ? DATA_W'(0) - s3_ff.v[k] : s3_ff.v[k];
         s4_in.sq[k]   = va * va;
         s4_in.cnum[k] = va * vel_limit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff <= '0;
      end else if (adv) begin
         s4_ff <= s4_in;
      end
   end

   // ---------------------------------------------------------------- S5: speed squared vs limit
   qside_type           s5_side_in, s5_side_ff;
   logic [2*DATA_W-1:0] s5_vsq_in, s5_vsq_ff;

   always_comb begin
      s5_vsq_in        = s4_ff.sq[0] + s4_ff.sq[1] + s4_ff.sq[2];
      s5_side_in.base  = s4_ff.base;
      s5_side_in.cnum  = s4_ff.cnum;
      s5_side_in.cap   = (vel_limit_ff != '0) && (s5_vsq_in > (2*DATA_W)'(lim_sq_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_side_ff <= '0;
      end else if (adv) begin
         s5_side_ff <= s5_side_in;
      end
      if (adv) begin
         s5_vsq_ff <= s5_vsq_in;
      end
   end

   // ---------------------------------------------------------------- square root
   logic [ROOT_W-1:0] sq_root;
   logic              sq_rem_nz;
   qside_type         sq_side;

   vvps_sqrt #(
      .IN_W  (2*DATA_W),
      .STEPS (DIV_STEPS)
   ) u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (s5_vsq_ff),
      .root     (sq_root),
      .rem_nz   (sq_rem_nz)
   );

   vvps_dly #(
      .W     ($bits(qside_type)),
      .DEPTH (SQRT_LAT)
   ) u_qdly (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .d     (s5_side_ff),
      .q     (sq_side)
   );

   // ---------------------------------------------------------------- S6: ceiling root
   cside_type                  s6_side_in, s6_side_ff;
   logic [ROOT_W:0]            s6_r_in, s6_r_ff;
   logic [2:0][CDIV_NUM_W-1:0] s6_cnum_ff;

   always_comb begin
      s6_side_in.base = sq_side.base;
      s6_side_in.cap  = sq_side.cap;
      s6_r_in         = {1'b0, sq_root} + (ROOT_W + 1)'(sq_rem_nz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_side_ff <= '0;
      end else if (adv) begin
         s6_side_ff <= s6_side_in;
      end
      if (adv) begin
         s6_r_ff    <= s6_r_in;
         s6_cnum_ff <= sq_side.cnum;
      end
   end

   // ---------------------------------------------------------------- cap dividers
   logic [CDIV_QW-1:0] cq [3];
   cside_type          cd_side;

   for (genvar k = 0; k < 3; k++) begin : g_cdiv
      vvps_div #(
         .NUM_W (CDIV_NUM_W),
         .DEN_W (ROOT_W + 1),
         .Q_W   (CDIV_QW),
         .STEPS (DIV_STEPS)
      ) u_cdiv (
         .clock (clock),
         .en    (adv),
         .num   (s6_cnum_ff[k]),
         .den   (s6_r_ff),
         .quot  (cq[k])
      );
   end

   vvps_dly #(
      .W     ($bits(cside_type)),
      .DEPTH (CDIV_LAT)
   ) u_cdly (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .d     (s6_side_ff),
      .q     (cd_side)
   );

   // ---------------------------------------------------------------- S7: capped velocity, estimate
   s7_type s7_in, s7_ff;

   always_comb begin
      logic [DATA_W-1:0]        vc;
      logic [DATA_W-1:0]        sm;
      logic signed [DATA_W:0]   hw;
      logic [DATA_W-1:0]        hs;
      sat_type                  se;
      s7_in.valid = cd_side.base.valid;
      s7_in.cmd   = cd_side.base.req.cmd;
      s7_in.er    = cd_side.base.req.energy_rate;
      s7_in.sat   = cd_side.base.sat;
      s7_in.cap   = cd_side.cap;
      s7_in.zm    = (cd_side.base.req.mass == '0);
      s7_in.esat  = 1'b0;
      for (int k = 0; k < 3; k++) begin
         vc = cd_side.base.v[k];
         if (cd_side.cap) begin
            vc = vc[DATA_W-1] ? DATA_W'(0) - {1'b0, cq[k]} : {1'b0, cq[k]};
         end
         // half smoothing velocity, truncated toward zero
         sm = lane_smooth(cd_side.base.req, k);
         hw = (DATA_W + 1)'($signed(sm)) + (DATA_W + 1)'(sm[DATA_W-1]);
         hs = xsph_ff ? hw[DATA_W:1] : '0;
         se = sat_data(64'($signed(vc)) + 64'($signed(cd_side.base.kick[k]))
                       - 64'($signed(hs)));
         s7_in.v[k]   = vc;
         s7_in.est[k] = se.val;
         s7_in.esat   = s7_in.esat | se.hit;
         s7_in.d[k]   = (DATA_W + 1)'($signed(vc)) - (DATA_W + 1)'($signed(hs));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ff <= '0;
      end else if (adv) begin
         s7_ff <= s7_in;
      end
   end

   // ---------------------------------------------------------------- S8: time step products
   s8_type s8_in, s8_ff;

   always_comb begin
      s8_in.valid = s7_ff.valid;
      s8_in.cmd   = s7_ff.cmd;
      s8_in.v     = s7_ff.v;
      s8_in.est   = s7_ff.est;
      s8_in.sat   = s7_ff.sat;
      s8_in.esat  = s7_ff.esat;
      s8_in.cap   = s7_ff.cap;
      s8_in.zm    = s7_ff.zm;
      for (int k = 0; k < 3; k++) begin
         s8_in.mprod[k] = $signed({1'b0, time_step_ff}) * $signed(s7_ff.d[k]);
      end
      s8_in.eprod = $signed({1'b0, time_step_ff}) * $signed(s7_ff.er);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_ff <= '0;
      end else if (adv) begin
         s8_ff <= s8_in;
      end
   end

   // ---------------------------------------------------------------- output register
   rsp_type rsp_data_in;

   always_comb begin
      sat_type sm0, sm1, sm2, sen;
      logic    initial_mode;
      logic    any_sat;
      initial_mode = (s8_ff.cmd == CMD_INITIAL);
      sm0 = sat_data(frac_trunc($signed(s8_ff.mprod[0])));
      sm1 = sat_data(frac_trunc($signed(s8_ff.mprod[1])));
      sm2 = sat_data(frac_trunc($signed(s8_ff.mprod[2])));
      sen = sat_data(frac_trunc($signed(s8_ff.eprod)));
      rsp_data_in.new_vel_x   = s8_ff.v[0];
      rsp_data_in.new_vel_y   = s8_ff.v[1];
      rsp_data_in.new_vel_z   = s8_ff.v[2];
      rsp_data_in.est_vel_x   = initial_mode ? s8_ff.est[0] : '0;
      rsp_data_in.est_vel_y   = initial_mode ? s8_ff.est[1] : '0;
      rsp_data_in.est_vel_z   = initial_mode ? s8_ff.est[2] : '0;
      rsp_data_in.move_x      = initial_mode ? sm0.val : '0;
      rsp_data_in.move_y      = initial_mode ? sm1.val : '0;
      rsp_data_in.move_z      = initial_mode ? sm2.val : '0;
      rsp_data_in.energy_step = initial_mode ? '0 : sen.val;
      rsp_data_in.was_capped  = s8_ff.cap;
      any_sat = s8_ff.sat | (initial_mode ? (s8_ff.esat | sm0.hit | sm1.hit | sm2.hit)
                                          : sen.hit);
      if (s8_ff.zm) begin
         rsp_data_in.fault = FAULT_ZERO_MASS;
      end else if (any_sat) begin
         rsp_data_in.fault = FAULT_SAT;
      end else begin
         rsp_data_in.fault = FAULT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s8_ff.valid;
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   logic [DATA_W-1:0] chk_mag [3];

   always_comb begin
      chk_mag[0] = rsp_data_ff.new_vel_x[DATA_W-1] ? DATA_W'(0) - rsp_data_ff.new_vel_x
                                                   : rsp_data_ff.new_vel_x;
      chk_mag[1] = rsp_data_ff.new_vel_y[DATA_W-1] ? DATA_W'(0) - rsp_data_ff.new_vel_y
                                                   : rsp_data_ff.new_vel_y;
      chk_mag[2] = rsp_data_ff.new_vel_z[DATA_W-1] ? DATA_W'(0) - rsp_data_ff.new_vel_z
                                                   : rsp_data_ff.new_vel_z;
   end

   // a capped velocity never exceeds the limit in any component
   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.was_capped |->
         vel_limit_ff != '0 && chk_mag[0] <= DATA_W'(vel_limit_ff)
         && chk_mag[1] <= DATA_W'(vel_limit_ff) && chk_mag[2] <= DATA_W'(vel_limit_ff))
      else $error("capped velocity above limit");

   // energy output and position/estimate outputs never both active
   a_mode_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.energy_step != '0 |->
         rsp_data_ff.move_x == '0 && rsp_data_ff.move_y == '0 && rsp_data_ff.move_z == '0
         && rsp_data_ff.est_vel_x == '0 && rsp_data_ff.est_vel_y == '0
         && rsp_data_ff.est_vel_z == '0)
      else $error("final-mode and initial-mode results mixed");

   // a stall freezes the S7 and S8 pipeline stages
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(s8_ff) && $stable(s7_ff))
      else $error("pipeline moved during stall");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s8_ff.valid)
      else $error("result valid after reset");

endmodule

>>> test/velocity_verlet_particle_step_core_tb.sv
// Self-checking testbench for velocity_verlet_particle_step_core.
// Runs a directed table, then random particle beats under changing settings and backpressure.
// Depends on vvps_pkg and the core RTL; checks every result beat against its own Q16.16 predictor.
module velocity_verlet_particle_step_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vvps_pkg::*;

   localparam int PIPE_LAT    = 62;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_BEATS = 82;
   localparam longint MAX31   = 64'h7FFF_FFFF;

   // idle patterns
   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [30:0] csr_wdata = '0;

   velocity_verlet_particle_step_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // local copy of the CSRs
   longint dt_q, half_kick_q, speed_cap_q;
   bit     xsph_q;

   rsp_type pending_rsp[$];
   int      mismatches = 0;
   int      cycles = 0;
   int      beats_sent = 0;
   int      beats_checked = 0;
   int      capped_seen = 0;
   int      idle_mode = IDLE_NONE;
   logic    req_took = 1'b0;
   bit      cur_typed = 1'b0;
   rsp_type cur_typed_rsp = '0;

   string field_names[12] = '{"new_vel_x", "new_vel_y", "new_vel_z", "est_vel_x",
      "est_vel_y", "est_vel_z", "move_x", "move_y", "move_z", "energy_step",
      "was_capped", "fault"};

   function automatic longint clamp32(input longint x, inout bit hit);
      if (x > 64'sd2147483647) begin
         hit = 1'b1;
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         hit = 1'b1;
         return -64'sd2147483648;
      end
      return x;
   endfunction

   // ceiling integer square root
   function automatic longint unsigned root_up(input longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= v) r = t;
      end
      if (r * r < v) r++;
      return r;
   endfunction

   // expected result of one particle beat under the current CSR copy
   function automatic rsp_type verlet_step(input req_type d);
      rsp_type         o;
      longint          vin[3], frc[3], smo[3], kick[3], v[3];
      longint          mass, hs, es;
      longint unsigned vsq, mag, r;
      bit              hit;
      bit              first;
      logic [31:0]     nv[3], ev[3], mv[3];
      hit = 1'b0;
      first = (d.cmd == CMD_INITIAL);
      mass = longint'(d.mass);
      vin = '{longint'(d.vel_x), longint'(d.vel_y), longint'(d.vel_z)};
      frc = '{longint'(d.force_x), longint'(d.force_y), longint'(d.force_z)};
      smo = '{longint'(d.smooth_x), longint'(d.smooth_y), longint'(d.smooth_z)};
      for (int k = 0; k < 3; k++) begin
         kick[k] = 0;
         if (mass != 0) begin
            kick[k] = (half_kick_q * frc[k]) / mass;
            if (kick[k] > (64'sd1 << 40)) kick[k] = 64'sd1 << 40;
            if (kick[k] < -(64'sd1 << 40)) kick[k] = -(64'sd1 << 40);
         end
         v[k] = clamp32(vin[k] + kick[k], hit);
      end
      o.was_capped = 1'b0;
      if (speed_cap_q != 0) begin
         vsq = 0;
         for (int k = 0; k < 3; k++) begin
            mag = (v[k] < 0) ? -v[k] : v[k];
            vsq += mag * mag;
         end
         if (vsq > longint'(speed_cap_q) * speed_cap_q) begin
            r = root_up(vsq);
            o.was_capped = 1'b1;
            for (int k = 0; k < 3; k++) v[k] = (v[k] * speed_cap_q) / longint'(r);
         end
      end
      for (int k = 0; k < 3; k++) begin
         nv[k] = v[k][31:0];
         ev[k] = '0;
         mv[k] = '0;
         if (first) begin
            hs = xsph_q ? smo[k] / 2 : 0;
            ev[k] = 32'(clamp32(v[k] + kick[k] - hs, hit));
            mv[k] = 32'(clamp32((dt_q * (v[k] - hs)) / 65536, hit));
         end
      end
      es = first ? 0 : clamp32((dt_q * longint'(d.energy_rate)) / 65536, hit);
      o.new_vel_x = nv[0]; o.new_vel_y = nv[1]; o.new_vel_z = nv[2];
      o.est_vel_x = ev[0]; o.est_vel_y = ev[1]; o.est_vel_z = ev[2];
      o.move_x = mv[0]; o.move_y = mv[1]; o.move_z = mv[2];
      o.energy_step = es[31:0];
      o.fault = (mass == 0) ? FAULT_ZERO_MASS : (hit ? FAULT_SAT : FAULT_OK);
      return o;
   endfunction

   function automatic void split_rsp(input rsp_type r, output longint f[12]);
      f = '{longint'(r.new_vel_x), longint'(r.new_vel_y), longint'(r.new_vel_z),
            longint'(r.est_vel_x), longint'(r.est_vel_y), longint'(r.est_vel_z),
            longint'(r.move_x), longint'(r.move_y), longint'(r.move_z),
            longint'(r.energy_step), longint'(r.was_capped), longint'(r.fault)};
   endfunction

   // request side: record the expectation of every accepted beat
   // response side: compare every accepted result beat
   always @(posedge clock) begin
      rsp_type exp_r;
      longint  ef[12], af[12];
      bit      bad;
      cycles <= cycles + 1;
      req_took <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         pending_rsp.push_back(cur_typed ? cur_typed_rsp : verlet_step(req_data));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (rsp_data.was_capped) capped_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
         end else begin
            exp_r = pending_rsp.pop_front();
            split_rsp(exp_r, ef);
            split_rsp(rsp_data, af);
            bad = 1'b0;
            for (int i = 0; i < 12; i++) begin
               if (ef[i] != af[i]) begin
                  bad = 1'b1;
                  if (mismatches < 10)
                     $display("ERROR: beat %0d %s expected %0d got %0d",
                              beats_checked, field_names[i], ef[i], af[i]);
               end
            end
            if (bad) mismatches++;
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (idle_mode == IDLE_RECV)
         rsp_ready <= ($urandom_range(99) >= 48);
      else if (idle_mode == IDLE_BOTH)
         rsp_ready <= ($urandom_range(99) >= 15);
      else
         rsp_ready <= 1'b1;
   end

   // one beat, held until accepted; called at a falling edge
   task automatic send_beat(input req_type d, input bit typed, input rsp_type typed_rsp);
      int gap_pct;
      gap_pct = (idle_mode == IDLE_SEND) ? 48 : (idle_mode == IDLE_BOTH) ? 15 : 0;
      // each idle cycle is drawn on its own
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data = d;
      cur_typed = typed;
      cur_typed_rsp = typed_rsp;
      req_valid = 1'b1;
      do @(negedge clock); while (!req_took);
      beats_sent++;
   endtask

   // wait until every expected result beat has come back
   task automatic drain();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (PIPE_LAT + 4) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input longint val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val[30:0];
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_TIME_STEP: dt_q = val & MAX31;
         CSR_HALF_STEP: half_kick_q = val & MAX31;
         CSR_VEL_LIMIT: speed_cap_q = val & MAX31;
         CSR_XSPH:      xsph_q = val[0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input longint dt, input longint hk, input longint cap,
                                input bit xs);
      csr_write(CSR_TIME_STEP, dt);
      csr_write(CSR_HALF_STEP, hk);
      csr_write(CSR_VEL_LIMIT, cap);
      csr_write(CSR_XSPH, longint'(xs));
   endtask

   function automatic logic [31:0] rand_q();
      case ($urandom_range(5))
         0: return $urandom();
         1: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
         2: case ($urandom_range(4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'h1;
               default: return 32'hFFFF_FFFF;
            endcase
         default: return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
      endcase
   endfunction

   function automatic longint rand_setting(input bit allow_zero);
      case ($urandom_range(4))
         0: return allow_zero ? 0 : 1;
         1: return MAX31;
         2: return $urandom_range(1, 32'h4_0000);
         3: return $urandom_range(32'h100, 32'h100_0000);
         default: return $urandom() & MAX31;
      endcase
   endfunction

   function automatic req_type rand_particle();
      req_type d;
      d.cmd = $urandom_range(1) ? CMD_FINAL : CMD_INITIAL;
      d.vel_x = rand_q(); d.vel_y = rand_q(); d.vel_z = rand_q();
      d.force_x = rand_q(); d.force_y = rand_q(); d.force_z = rand_q();
      case ($urandom_range(19))
         0: d.mass = '0;
         1, 2, 3, 4, 5, 6: d.mass = 31'($urandom());
         default: d.mass = 31'($urandom_range(1, 32'h4_0000));
      endcase
      d.smooth_x = rand_q(); d.smooth_y = rand_q(); d.smooth_z = rand_q();
      d.energy_rate = rand_q();
      return d;
   endfunction

   // directed table: setting group, beat, and a typed expectation where obvious
   typedef struct {
      int      group;
      req_type d;
      bit      typed;
      rsp_type r;
   } row_type;

   row_type rows[$];

   function automatic req_type mk(input logic c, input logic [31:0] v, input logic [31:0] f,
                                  input logic [30:0] m, input logic [31:0] s,
                                  input logic [31:0] e);
      req_type d;
      d.cmd = c;
      d.vel_x = v; d.vel_y = -v; d.vel_z = v >>> 1;
      d.force_x = f; d.force_y = -f; d.force_z = f;
      d.mass = m;
      d.smooth_x = s; d.smooth_y = -s; d.smooth_z = s;
      d.energy_rate = e;
      return d;
   endfunction

   // with all CSRs at reset the velocity passes, est copies it in initial mode
   function automatic void add_quiet(input req_type d);
      row_type w;
      w.group = 0;
      w.d = d;
      w.typed = 1'b1;
      w.r = '0;
      w.r.new_vel_x = d.vel_x; w.r.new_vel_y = d.vel_y; w.r.new_vel_z = d.vel_z;
      if (d.cmd == CMD_INITIAL) begin
         w.r.est_vel_x = d.vel_x; w.r.est_vel_y = d.vel_y; w.r.est_vel_z = d.vel_z;
      end
      w.r.fault = (d.mass == 0) ? FAULT_ZERO_MASS : FAULT_OK;
      rows.push_back(w);
   endfunction

   function automatic void add_row(input int g, input req_type d);
      row_type w;
      w.group = g;
      w.d = d;
      w.typed = 1'b0;
      w.r = '0;
      rows.push_back(w);
   endfunction

   initial begin
      int     last_group;
      req_type d;
      dt_q = 0; half_kick_q = 0; speed_cap_q = 0; xsph_q = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: nothing moves, energy zero
      add_quiet(mk(CMD_INITIAL, 32'h0001_0000, 32'h7FFF_FFFF, 31'h1_0000, 32'h0, 32'h0));
      add_quiet(mk(CMD_INITIAL, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF));
      add_quiet(mk(CMD_FINAL, 32'h8000_0000, 32'h1234_5678, 31'h1, 32'h7FFF_FFFF,
                   32'h8000_0000));
      add_quiet(mk(CMD_INITIAL, 32'hFFFF_0000, 32'h0001_0000, 31'h0, 32'h0, 32'h0));
      add_quiet(mk(CMD_FINAL, 32'h0, 32'h0, 31'h0, 32'h0, 32'h1));
      // unit step, half kick, smoothing on
      add_row(1, mk(CMD_INITIAL, 32'h0002_0000, 32'h0004_0000, 31'h2_0000, 32'h0001_0000,
                    32'h0));
      add_row(1, mk(CMD_INITIAL, 32'h0, 32'h0, 31'h0, 32'hFFFF_FFFF, 32'h0));
      add_row(1, mk(CMD_FINAL, 32'h0003_8000, 32'hFFFE_0000, 31'h1_0000, 32'h0,
                    32'hFFFF_8000));
      add_row(1, mk(CMD_INITIAL, 32'h7FFF_FFFF, 32'h0, 31'h1_0000, 32'h8000_0000, 32'h0));
      add_row(1, mk(CMD_INITIAL, 32'h8000_0001, 32'h0, 31'h1_0000, 32'h7FFF_FFFF, 32'h0));
      // extremes: kick clamp, saturation of every output
      add_row(2, mk(CMD_INITIAL, 32'h0, 32'h7FFF_FFFF, 31'h1, 32'h0, 32'h0));
      add_row(2, mk(CMD_INITIAL, 32'h7FFF_FFFF, 32'h8000_0000, 31'h1, 32'h8000_0000, 32'h0));
      add_row(2, mk(CMD_FINAL, 32'h1, 32'h1, 31'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF));
      add_row(2, mk(CMD_FINAL, 32'h0, 32'h0, 31'h0, 32'h0, 32'h8000_0000));
      add_row(2, mk(CMD_INITIAL, 32'h0000_0001, 32'h0, 31'h0, 32'h0, 32'h0));
      // unit speed cap
      add_row(3, mk(CMD_INITIAL, 32'h0003_0000, 32'h0, 31'h1_0000, 32'h0002_0000, 32'h0));
      add_row(3, mk(CMD_INITIAL, 32'h0000_8000, 32'h0, 31'h1_0000, 32'h0, 32'h0));
      add_row(3, mk(CMD_FINAL, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 32'h0,
                    32'h0001_0000));
      add_row(3, mk(CMD_INITIAL, 32'h0000_B505, 32'h0, 31'h0, 32'h0, 32'h0));
      add_row(3, mk(CMD_INITIAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h1, 32'h7FFF_FFFF, 32'h0));
      // widest cap, smoothing off
      add_row(4, mk(CMD_INITIAL, 32'h7FFF_FFFF, 32'h0, 31'h1_0000, 32'h0, 32'h0));
      add_row(4, mk(CMD_INITIAL, 32'h8000_0000, 32'h8000_0000, 31'h1, 32'h0, 32'h0));

      last_group = 0;
      foreach (rows[i]) begin
         if (rows[i].group != last_group) begin
            drain();
            case (rows[i].group)
               1: load_settings(64'h1_0000, 64'h8000, 0, 1'b1);
               2: load_settings(MAX31, MAX31, 0, 1'b0);
               3: load_settings(64'h1_0000, 64'h1_0000, 64'h1_0000, 1'b1);
               default: load_settings(64'h1_0000, 64'h1_0000, MAX31, 1'b0);
            endcase
            last_group = rows[i].group;
         end
         send_beat(rows[i].d, rows[i].typed, rows[i].r);
      end

      // random phases, each with fresh settings and its own idle pattern
      for (int p = 0; p < RAND_PHASES; p++) begin
         drain();
         idle_mode = p % 4;
         if (p == 0) load_settings(MAX31, MAX31, MAX31, 1'b1);
         else if (p == 1) load_settings(0, 0, 1, 1'b0);
         else load_settings(rand_setting(1), rand_setting(1), rand_setting(1),
                            $urandom_range(1));
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // hold off until the pipeline is empty, then resume
            if (p == 2 && n == PHASE_BEATS / 2) begin
               req_valid = 1'b0;
               while (pending_rsp.size() != 0) @(negedge clock);
            end
            d = rand_particle();
            send_beat(d, 1'b0, '0);
         end
      end

      drain();
      idle_mode = IDLE_NONE;
      $display("Run covered %0d particle beats (%0d results checked, %0d capped)",
               beats_sent, beats_checked, capped_seen);
      $display("over %0d settings with and without backpressure; %0d mismatching beats",
               RAND_PHASES + 5, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/vvps_pkg.sv
hw/rtl/vvps_div.sv
hw/rtl/vvps_sqrt.sv
hw/rtl/vvps_dly.sv
hw/rtl/velocity_verlet_particle_step_core.sv
test/velocity_verlet_particle_step_core_tb.sv
